// ===== src/length_prefixed_deframer_core_assert.svh =====
// Assertion macros shared by the deframer modules.
// Each macro expects clk and arst_n to be visible in the module that uses it.
`ifndef LENGTH_PREFIXED_DEFRAMER_CORE_ASSERT_SVH
`define LENGTH_PREFIXED_DEFRAMER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LPD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("deframer check failed");

// Next-cycle implication, checked outside reset.
`define LPD_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("deframer check failed");

// Invariant that holds at every edge outside reset.
`define LPD_ASSERT_ALW(lbl, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cons)) \
		else $error("deframer check failed");

`endif

// ===== src/lpd_pkg.sv =====
// Shared types and constants for the length-prefixed deframer.
// No dependencies; the interface, parser, buffer and top-level files import this package.
`default_nettype none

package lpd_pkg;

	// Header layout: eight bytes, length field in bytes 4 to 7.
	localparam logic [3:0] HDR_BYTES = 4'd8;
	localparam logic [3:0] LEN_START = 4'd4;

	// Reset value of the size limit register.
	localparam logic [30:0] SIZE_LIMIT_RST = 31'd65536;

	typedef enum logic [1:0] {
		KIND_PAYLOAD  = 2'd0,
		KIND_EMPTY    = 2'd1,
		KIND_OVERSIZE = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  payload_byte;
		logic [30:0] message_length;
		logic        last;
	} result_t;

endpackage

`default_nettype wire

// ===== src/lpd_if.sv =====
// Valid/ready channel interfaces for the deframer: byte input and result output.
// Depends on lpd_pkg for the result kind type.
`default_nettype none

interface lpd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

interface lpd_out_if
	import lpd_pkg::*;
;
	logic        valid;
	logic        ready;
	kind_t       kind;
	logic [7:0]  payload_byte;
	logic [30:0] message_length;
	logic        last;

	modport source (output valid, output kind, output payload_byte, output message_length,
		output last, input ready);
	modport sink (input valid, input kind, input payload_byte, input message_length,
		input last, output ready);
endinterface

`default_nettype wire

// ===== src/lpd_parse.sv =====
// Header/payload parser: holds the framing state and the size limit register,
// and turns one byte into at most one result. Depends on lpd_pkg.
`default_nettype none
`include "length_prefixed_deframer_core_assert.svh"

module lpd_parse
	import lpd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [30:0] cfg_wr_data,
	input  wire logic        step,
	input  wire logic [7:0]  data_byte,
	output logic             res_valid,
	output result_t          res
);

	logic [3:0]  hdr_pos_q;
	logic [31:0] length_q;
	logic [30:0] remaining_q;
	logic        halted_q;
	logic [30:0] size_limit_q;

	logic [3:0]  hdr_pos_d;
	logic [31:0] length_d;
	logic [30:0] remaining_d;
	logic        halted_d;
	logic [31:0] len_hdr;
	logic [3:0]  hdr_pos_inc;
	logic        oversize;

	// Assemble the length field as header bytes arrive.
	always_comb begin
		len_hdr = (hdr_pos_q == '0) ? '0 : length_q;
		if (hdr_pos_q >= LEN_START) begin
			len_hdr[{hdr_pos_q[1:0], 3'b000} +: 8] = len_hdr[{hdr_pos_q[1:0], 3'b000} +: 8]
				| data_byte;
		end
	end

	assign hdr_pos_inc = 4'(hdr_pos_q + 4'd1);
	assign oversize    = len_hdr[31] || (len_hdr[30:0] >= size_limit_q);

	// Next state and result for one byte.
	always_comb begin
		hdr_pos_d          = hdr_pos_q;
		length_d           = length_q;
		remaining_d        = remaining_q;
		halted_d           = halted_q;
		res_valid          = 1'b0;
		res.kind           = KIND_PAYLOAD;
		res.payload_byte   = '0;
		res.message_length = '0;
		res.last           = 1'b0;
		if (step && !halted_q) begin
			if (hdr_pos_q < HDR_BYTES) begin
				length_d  = len_hdr;
				hdr_pos_d = hdr_pos_inc;
				if (hdr_pos_inc == HDR_BYTES) begin
					if (oversize) begin
						halted_d           = 1'b1;
						res_valid          = 1'b1;
						res.kind           = KIND_OVERSIZE;
						res.message_length = len_hdr[30:0];
					end else if (len_hdr == '0) begin
						hdr_pos_d = '0;
						res_valid = 1'b1;
						res.kind  = KIND_EMPTY;
						res.last  = 1'b1;
					end else begin
						remaining_d = len_hdr[30:0];
					end
				end
			end else begin
				res_valid          = 1'b1;
				res.kind           = KIND_PAYLOAD;
				res.payload_byte   = data_byte;
				res.message_length = length_q[30:0];
				res.last           = (remaining_q <= 31'd1);
				if (remaining_q != '0) begin
					remaining_d = 31'(remaining_q - 31'd1);
				end
				if (remaining_d == '0) begin
					hdr_pos_d = '0;
				end
			end
		end
	end

	// Hold framing state; clear on reset (reset stands in for a disconnect).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_pos_q   <= '0;
			length_q    <= '0;
			remaining_q <= '0;
			halted_q    <= 1'b0;
		end else begin
			hdr_pos_q   <= hdr_pos_d;
			length_q    <= length_d;
			remaining_q <= remaining_d;
			halted_q    <= halted_d;
		end
	end

	// Size limit register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_limit_q <= SIZE_LIMIT_RST;
		end else if (cfg_wr_en) begin
			size_limit_q <= cfg_wr_data;
		end
	end

	`LPD_ASSERT_ALW(a_hdr_pos_range, hdr_pos_q <= HDR_BYTES)
	`LPD_ASSERT_NXT(a_halt_sticky, halted_q, halted_q)
	`LPD_ASSERT_IMP(a_no_result_halted, halted_q, !res_valid)
	`LPD_ASSERT_IMP(a_payload_has_count, step && hdr_pos_q == HDR_BYTES && !halted_q,
		remaining_q != '0)

endmodule

`default_nettype wire

// ===== src/lpd_skid.sv =====
// Two-entry output buffer (result register plus skid slot) driving the result
// channel. Depends on lpd_pkg and lpd_if.
`default_nettype none
`include "length_prefixed_deframer_core_assert.svh"

module lpd_skid
	import lpd_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push,
	input  wire result_t push_data,
	output logic        push_ready,
	lpd_out_if.source   result
);

	result_t out_q;
	result_t skid_q;
	logic    out_valid_q;
	logic    skid_valid_q;
	logic    pop;

	assign pop        = out_valid_q && result.ready;
	assign push_ready = !skid_valid_q;

	// Track occupancy of the two slots.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (pop && skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else if (push && out_valid_q && !pop) begin
				skid_valid_q <= 1'b1;
			end
			if (push || skid_valid_q) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Advance the payload: skid drains first, else new beat lands in the result slot.
	always_ff @(posedge clk) begin
		if (pop && skid_valid_q) begin
			out_q <= skid_q;
		end else if (push && (!out_valid_q || pop)) begin
			out_q <= push_data;
		end
		if (push && out_valid_q && !pop) begin
			skid_q <= push_data;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.kind           = out_q.kind;
	assign result.payload_byte   = out_q.payload_byte;
	assign result.message_length = out_q.message_length;
	assign result.last           = out_q.last;

	`LPD_ASSERT_IMP(a_skid_implies_out, skid_valid_q, out_valid_q)
	`LPD_ASSERT_IMP(a_no_push_when_full, push, !skid_valid_q)
	`LPD_ASSERT_NXT(a_push_shows, push, out_valid_q)

endmodule

`default_nettype wire

// ===== src/length_prefixed_deframer_core.sv =====
// Top level of the length-prefixed deframer: input byte register, parser and
// output buffer. Depends on lpd_pkg, lpd_if, lpd_parse and lpd_skid.
`default_nettype none

// Cuts a received byte stream into messages with an 8-byte header whose bytes
// 4 to 7 carry the little-endian payload length. Each payload byte leaves as
// one result beat with the message length and a last flag; a zero-length
// message gives one empty-message beat, and a length of 2^31 or more or at or
// above size_limit gives one oversize beat, after which all bytes are dropped
// until arst_n. One byte is taken every cycle while stream ready is high: the
// parser updates its header counter, length and remaining count as each byte
// steps in, and each result passes from the input register through the parser
// into the output buffer before it is shown on the result channel. Stream ready
// drops only when the input register and both output slots are all occupied.
// Write size_limit only while the block is idle.
module length_prefixed_deframer_core
	import lpd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [30:0] cfg_wr_data,
	lpd_in_if.sink           stream,
	lpd_out_if.source        result
);

	logic       valid_s1;
	logic [7:0] data_s1;
	logic       push_ready;
	logic       advance;
	logic       res_valid;
	result_t    res;

	assign advance      = valid_s1 && push_ready;
	assign stream.ready = !valid_s1 || push_ready;

	// Input register: hold the beat until the parser can take it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.ready) begin
			valid_s1 <= stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.ready && stream.valid) begin
			data_s1 <= stream.data_byte;
		end
	end

	lpd_parse u_parse (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.step        (advance),
		.data_byte   (data_s1),
		.res_valid   (res_valid),
		.res         (res)
	);

	lpd_skid u_skid (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (res_valid),
		.push_data  (res),
		.push_ready (push_ready),
		.result     (result)
	);

endmodule

`default_nettype wire
